// ===== sv/bfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the binaural FIR mixer: defaults, field widths, codes and the
// sequencer state type. Depends on nothing.
package bfm_pkg;

  localparam int CHANNELS_DEF    = 12;
  localparam int TAPS_DEF        = 128;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 18;

  // Width of the channel field and of the LFE register.
  localparam int CH_W = 4;

  localparam logic [CH_W-1:0] LFE_RESET = 4'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic EAR_LEFT  = 1'b0;
  localparam logic EAR_RIGHT = 1'b1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MAC   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_ROUND = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

// ===== sv/binaural_fir_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A coefficient request or an LFE sample is handled in S_IDLE; a filtered sample
// runs through S_MAC, S_DRAIN and S_ROUND on the shared multiply-accumulate unit that
// visits one tap per cycle. A stereo result appears after the last channel.
// Reset: synchronous; it starts a clearing pass over the CHANNELS << clog2(TAPS)
// addresses (1536 by default) of the three stores, with no request taken meanwhile.
// Top level of the binaural FIR mixer; depends on bfm_pkg.
module binaural_fir_mixer
  import bfm_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  localparam int TAP_W      = $clog2(TAPS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CH_W-1:0]               lfe_channel,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic [CH_W-1:0]               channel,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic [TAP_W-1:0]              tap,
  input  wire logic                          ear,
  input  wire logic signed [COEF_BITS-1:0]   coefficient,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out
);

  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS << TAP_W;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W     = PROD_W + TAP_W + 1;
  localparam int COEF_FRAC = COEF_BITS - 2;
  localparam int SUM_W     = ACC_W - COEF_FRAC + CH_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(1) <<< (COEF_FRAC - 1);

  state_t state;

  logic [CH_W-1:0]  lfe_reg;
  logic [ADDR_W-1:0] clr_addr;
  logic [CH_AW-1:0] ch_reg;
  logic             last_ch;
  logic [TAP_W-1:0] pos;
  logic [TAP_W-1:0] k;
  logic [TAP_W-1:0] hidx;
  logic             rd_v;
  logic             mul_v;

  logic signed [SAMPLE_BITS-1:0] hist_mem [MEM_DEPTH];
  logic signed [COEF_BITS-1:0]   left_mem [MEM_DEPTH];
  logic signed [COEF_BITS-1:0]   right_mem[MEM_DEPTH];

  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic signed [COEF_BITS-1:0]   lt_q;
  logic signed [COEF_BITS-1:0]   rt_q;
  logic signed [PROD_W-1:0]      prod_l;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_l;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [SUM_W-1:0]       sum_l;
  logic signed [SUM_W-1:0]       sum_r;

  logic                   accept;
  logic                   ch_ok;
  logic                   is_lfe;
  logic                   is_last;
  logic                   hist_we;
  logic [ADDR_W-1:0]      hist_waddr;
  logic [SAMPLE_BITS-1:0] hist_wdata;
  logic                   left_we;
  logic                   right_we;
  logic [ADDR_W-1:0]      coef_waddr;
  logic [COEF_BITS-1:0]   coef_wdata;
  logic [ADDR_W-1:0]      hist_raddr;
  logic [ADDR_W-1:0]      coef_raddr;
  logic signed [SUM_W-1:0] half_s;
  logic signed [ACC_W-1:0] rnd_l;
  logic signed [ACC_W-1:0] rnd_r;
  logic signed [SUM_W-1:0] add_l;
  logic signed [SUM_W-1:0] add_r;
  logic                    emit_go;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign ch_ok     = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));
  assign is_lfe    = (channel == lfe_reg);
  assign is_last   = ({1'b0, channel} == (CH_W + 1)'(CHANNELS - 1));
  assign emit_go   = !out_valid || out_ready;

  // Store write ports: the clearing pass takes priority, as nothing else runs then.
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = ADDR_W'({channel[CH_AW-1:0], pos});
    hist_wdata = sample;
    left_we    = 1'b0;
    right_we   = 1'b0;
    coef_waddr = ADDR_W'({channel[CH_AW-1:0], tap});
    coef_wdata = coefficient;
    if (state == S_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_addr;
      hist_wdata = '0;
      left_we    = 1'b1;
      right_we   = 1'b1;
      coef_waddr = clr_addr;
      coef_wdata = '0;
    end else if (accept && ch_ok) begin
      if (op == OP_SAMPLE) begin
        hist_we = !is_lfe;
      end else if ({1'b0, tap} < (TAP_W + 1)'(TAPS)) begin
        left_we  = (ear == EAR_LEFT);
        right_we = (ear == EAR_RIGHT);
      end
    end
  end

  assign hist_raddr = ADDR_W'({ch_reg, hidx});
  assign coef_raddr = ADDR_W'({ch_reg, k});

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[coef_waddr] <= coef_wdata;
    end
    lt_q <= left_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[coef_waddr] <= coef_wdata;
    end
    rt_q <= right_mem[coef_raddr];
  end

  // Multiply stage, one product per ear per tap.
  always_ff @(posedge clk) begin
    prod_l <= hist_q * lt_q;
    prod_r <= hist_q * rt_q;
  end

  assign half_s = SUM_W'(sample >>> 1);
  assign rnd_l  = acc_l + ROUND_K;
  assign rnd_r  = acc_r + ROUND_K;
  assign add_l  = SUM_W'(rnd_l >>> COEF_FRAC);
  assign add_r  = SUM_W'(rnd_r >>> COEF_FRAC);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (mul_v) begin
      acc_l <= acc_l + ACC_W'(prod_l);
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      lfe_reg   <= LFE_RESET;
      clr_addr  <= '0;
      ch_reg    <= '0;
      last_ch   <= 1'b0;
      pos       <= '0;
      k         <= '0;
      hidx      <= '0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      sum_l     <= '0;
      sum_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lfe_reg <= lfe_channel;
      end
      if (out_valid && out_ready && !(state == S_EMIT && emit_go)) begin
        out_valid <= 1'b0;
      end
      rd_v  <= (state == S_MAC);
      mul_v <= rd_v;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && ch_ok && op == OP_SAMPLE) begin
            ch_reg  <= channel[CH_AW-1:0];
            last_ch <= is_last;
            k       <= '0;
            hidx    <= pos;
            if (is_lfe) begin
              sum_l <= sum_l + half_s;
              sum_r <= sum_r + half_s;
              if (is_last) begin
                state <= S_EMIT;
              end
            end else begin
              state <= S_MAC;
            end
          end
        end
        S_MAC: begin
          k    <= k + TAP_W'(1);
          hidx <= (hidx == '0) ? TAP_W'(TAPS - 1) : hidx - TAP_W'(1);
          if (k == TAP_W'(TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Wait until the last product has reached the accumulators.
          if (!rd_v && !mul_v) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          sum_l <= sum_l + add_l;
          sum_r <= sum_r + add_r;
          state <= last_ch ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            left_out  <= (sum_l > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                         (sum_l < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : sum_l[SAMPLE_BITS-1:0];
            right_out <= (sum_r > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                         (sum_r < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : sum_r[SAMPLE_BITS-1:0];
            out_valid <= 1'b1;
            sum_l     <= '0;
            sum_r     <= '0;
            pos       <= (pos == TAP_W'(TAPS - 1)) ? '0 : pos + TAP_W'(1);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/bfm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the binaural FIR mixer, bound to the top level.
// Depends on bfm_pkg.
module bfm_checker
  import bfm_pkg::*;
#(
  parameter int TAP_W = 7,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready,
  input wire logic [CH_W-1:0]        lfe_channel,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   op,
  input wire logic [CH_W-1:0]        channel,
  input wire logic [SAMPLE_BITS-1:0] sample,
  input wire logic [TAP_W-1:0]       tap,
  input wire logic                   ear,
  input wire logic [COEF_BITS-1:0]   coefficient,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] left_out,
  input wire logic [SAMPLE_BITS-1:0] right_out
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("result changed while stalled");

  // Reset starts the clearing pass, so no request is taken just after it.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken during clearing pass");

  // A coefficient request finishes at once and leaves the block ready.
  a_coef_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_COEF |=> in_ready)
    else $error("coefficient request held the block busy");

  // A coefficient request never produces a result.
  a_coef_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_COEF |=> !$rose(out_valid))
    else $error("result raised by a coefficient request");

endmodule

bind binaural_fir_mixer bfm_checker #(
  .TAP_W(TAP_W),
  .SAMPLE_BITS(SAMPLE_BITS),
  .COEF_BITS(COEF_BITS)
) u_bfm_checker (.*);
`default_nettype wire

// ===== tb/tb_binaural_fir_mixer.sv =====
`timescale 1ns / 1ps
// Self-checking bench for binaural_fir_mixer: a predictor of the FIR mixing
// drives expected stereo results that are compared with the block's output.
// Depends on bfm_pkg and binaural_fir_mixer.
module tb_binaural_fir_mixer;
  import bfm_pkg::*;

  localparam int NCH   = 12;
  localparam int NTAPS = 128;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CH_W-1:0] lfe_channel = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_SAMPLE;
  logic [CH_W-1:0] channel = '0;
  logic signed [23:0] sample = '0;
  logic [6:0] tap = '0;
  logic ear = EAR_LEFT;
  logic signed [17:0] coefficient = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] left_out, right_out;

  binaural_fir_mixer dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .lfe_channel(lfe_channel),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .channel(channel),
    .sample(sample), .tap(tap), .ear(ear), .coefficient(coefficient),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_out(left_out), .right_out(right_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  longint hist[NCH*NTAPS];
  longint ltaps[NCH*NTAPS];
  longint rtaps[NCH*NTAPS];
  int unsigned frame_pos;
  longint lacc, racc;
  int unsigned lfe_sel;

  typedef struct {
    logic signed [23:0] l;
    logic signed [23:0] r;
  } stereo_t;
  stereo_t mix_queue[$];

  int errors = 0;
  longint cycles = 0;
  int burst_left = 0;

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Applies one accepted request to the predictor.
  task automatic predict_mix(logic iop, logic [3:0] ich, logic signed [23:0] ismp,
                             logic [6:0] itap, logic iear, logic signed [17:0] icoef);
    int unsigned b;
    int unsigned idx;
    longint sl, sr;
    stereo_t res;
    if (ich >= NCH) return;
    b = ich * NTAPS;
    if (iop == OP_COEF) begin
      if (iear == EAR_RIGHT) rtaps[b + itap] = icoef;
      else ltaps[b + itap] = icoef;
      return;
    end
    if (ich == lfe_sel) begin
      lacc += longint'(ismp) >>> 1;
      racc += longint'(ismp) >>> 1;
    end else begin
      hist[b + frame_pos] = ismp;
      sl = 0;
      sr = 0;
      for (int k = 0; k < NTAPS; k++) begin
        idx = (frame_pos + NTAPS - k) % NTAPS;
        sl += hist[b + idx] * ltaps[b + k];
        sr += hist[b + idx] * rtaps[b + k];
      end
      lacc += (sl + 32768) >>> 16;
      racc += (sr + 32768) >>> 16;
    end
    if (ich == NCH - 1) begin
      res.l = clamp24(lacc);
      res.r = clamp24(racc);
      mix_queue.push_back(res);
      lacc = 0;
      racc = 0;
      frame_pos = (frame_pos + 1) % NTAPS;
    end
  endtask

  // Valid stays high from one request to the next within a burst; it drops
  // only for a gap or when the sender stops.
  task automatic send_request(logic iop, logic [3:0] ich, logic signed [23:0] ismp,
                              logic [6:0] itap, logic iear, logic signed [17:0] icoef);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= iop;
    channel <= ich;
    sample <= ismp;
    tap <= itap;
    ear <= iear;
    coefficient <= icoef;
    do @(posedge clk); while (!in_ready);
    predict_mix(iop, ich, ismp, itap, iear, icoef);
  endtask

  task automatic load_coef(int ch, int t, logic e, logic signed [17:0] c);
    send_request(OP_COEF, 4'(ch), 24'($urandom), 7'(t), e, c);
  endtask

  task automatic play_frame(logic signed [23:0] fixed_val, bit use_fixed);
    for (int c = 0; c < NCH; c++)
      send_request(OP_SAMPLE, 4'(c), use_fixed ? fixed_val : 24'($urandom), 7'($urandom),
                   1'($urandom), 18'($urandom));
  endtask

  // LFE register changes only once the block has drained.
  task automatic write_lfe(logic [3:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    lfe_channel <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lfe_sel = v;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mix_queue.size() != 0) @(posedge clk);
    repeat (NTAPS + 20) @(posedge clk);
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) out_ready <= (cycles % 64) < 32 ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (mix_queue.size() == 0) begin
        $display("%0t: unexpected result L=%0d R=%0d", $time, left_out, right_out);
        errors++;
      end else begin
        if (left_out !== mix_queue[0].l) begin
          $display("%0t: left expected %0d actual %0d", $time, mix_queue[0].l, left_out);
          errors++;
        end
        if (right_out !== mix_queue[0].r) begin
          $display("%0t: right expected %0d actual %0d", $time, mix_queue[0].r, right_out);
          errors++;
        end
        void'(mix_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_extremes();
    load_coef(0, 0, EAR_LEFT, 18'sh1ffff);
    load_coef(0, 0, EAR_RIGHT, 18'sh20000);
    load_coef(0, 127, EAR_LEFT, 18'sh20000);
    load_coef(11, 1, EAR_RIGHT, 18'sh1ffff);
    load_coef(14, 5, EAR_LEFT, 18'sh1234);
    load_coef(3, 0, EAR_LEFT, 18'sh10000);
    play_frame(24'sh7fffff, 1'b1);
    play_frame(24'sh800000, 1'b1);
    send_request(OP_SAMPLE, 4'd15, 24'sh7fffff, 7'd0, EAR_LEFT, 18'sd0);
    send_request(OP_SAMPLE, 4'd0, 24'sh123456, 7'd0, EAR_LEFT, 18'sd0);
    send_request(OP_SAMPLE, 4'd0, 24'sh800001, 7'd0, EAR_LEFT, 18'sd0);
    send_request(OP_SAMPLE, 4'd11, 24'sh000001, 7'd0, EAR_LEFT, 18'sd0);
  endtask

  task automatic test_lfe_settings();
    write_lfe(4'd0);
    play_frame(24'sh7fffff, 1'b1);
    write_lfe(4'd11);
    play_frame(24'sh800000, 1'b1);
    write_lfe(4'd15);
    play_frame(24'sd0, 1'b0);
  endtask

  task automatic test_random_traffic();
    int n;
    n = 0;
    while (n < 750) begin
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 6)) begin
          load_coef($urandom_range(0, 12), $urandom, 1'($urandom), 18'($urandom));
          n++;
        end
      end else if ($urandom_range(0, 9) < 8) begin
        play_frame(24'sd0, 1'b0);
        n += NCH;
      end else begin
        send_request(OP_SAMPLE, 4'($urandom), 24'($urandom), 7'($urandom), 1'($urandom),
                     18'($urandom));
        n++;
      end
      if ($urandom_range(0, 99) == 0) write_lfe(4'($urandom_range(0, 11)));
    end
    write_lfe(LFE_RESET);
    play_frame(24'sd0, 1'b0);
  endtask

  initial begin
    foreach (hist[i]) begin
      hist[i] = 0;
      ltaps[i] = 0;
      rtaps[i] = 0;
    end
    frame_pos = 0;
    lacc = 0;
    racc = 0;
    lfe_sel = LFE_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_lfe_settings();
    test_random_traffic();
    wait_drained();
    if (errors == 0 && mix_queue.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bfm_pkg.sv
sv/binaural_fir_mixer.sv
sv/bfm_checker.sv
tb/tb_binaural_fir_mixer.sv
